FILE: hw/rtl/tetbl_pkg.sv
// Shared types and codes for the tracked entry table with aging.
package tetbl_pkg;

  // Operation codes carried by an input beat.
  localparam logic [1:0] OP_UPDATE   = 2'd0;
  localparam logic [1:0] OP_INIT     = 2'd1;
  localparam logic [1:0] OP_SHUTDOWN = 2'd2;

  // Result status codes.
  localparam logic [2:0] STAT_REFRESH = 3'd0;
  localparam logic [2:0] STAT_INSERT  = 3'd1;
  localparam logic [2:0] STAT_FULL    = 3'd2;
  localparam logic [2:0] STAT_IGNORED = 3'd3;
  localparam logic [2:0] STAT_CLEARED = 3'd4;

  // Configuration register byte addresses and reset value.
  localparam int          ADDR_W       = 3;
  localparam logic [2:0]  ADDR_EXPIRY  = 3'd0;
  localparam logic [11:0] EXPIRY_RESET = 12'd30;

  // One input beat.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [8:0]  cell_identity;
    logic [22:0] carrier_freq_khz;
    logic [31:0] now_seconds;
    logic [63:0] cell_record;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic [2:0] status;
    logic [5:0] slot_index;
    logic [6:0] live_count;
    logic [6:0] expired_count;
  } result_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic        clear;
    logic        write;
    logic        any_hit;
    logic [8:0]  ident;
    logic [22:0] freq;
    logic [31:0] now;
    logic [63:0] record;
    logic [11:0] expiry;
  } cell_ctrl_t;

  // Priority tokens handed from one cell to the next.
  typedef struct packed {
    logic hit;
    logic free;
  } chain_t;

endpackage

FILE: hw/rtl/tetbl_if.sv
// Valid/ready channel interfaces for input items and results.
interface tetbl_item_if;
  logic                valid;
  logic                ready;
  tetbl_pkg::item_t    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tetbl_result_if;
  logic                valid;
  logic                ready;
  tetbl_pkg::result_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/tracked_entry_table_with_aging_core.sv
// Top level: sequencer, chain of entry cells, expiry counter tree and APB registers.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-----------------------------------------------
//  item     | in  | valid / ready | opcode, cell_identity, carrier_freq_khz, ...
//  result   | out | valid / ready | status, slot_index, live_count, expired_count
//  apb      | in  | psel/penable  | expiry_seconds at byte address 0
//
// An update goes through key and age compare, priority chain and write,
// log2(TABLE_ENTRIES) folds of the expired-entry counter tree, and the result register.
// The item channel is ready again once the result register is loaded. Init, shutdown
// and ignored beats go straight to the result register. Reset leaves the table empty
// and disabled with expiry_seconds at 30; a stalled result holds the sequencer in S_DONE.
module tracked_entry_table_with_aging_core #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  tetbl_item_if.sink                   item,
  tetbl_result_if.source               result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tetbl_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int IW  = $clog2(TABLE_ENTRIES);
  localparam int CW  = $clog2(TABLE_ENTRIES + 1);
  localparam int LV  = IW;
  localparam int P   = 1 << LV;
  localparam int FCW = $clog2(LV + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_WRITE,
    S_FOLD,
    S_DONE
  } state_t;

  state_t                 state;
  tetbl_pkg::item_t       cur;
  logic                   en;
  logic                   upd;
  logic [2:0]             res_status;
  logic [IW-1:0]          res_slot;
  logic [CW-1:0]          act;
  logic [FCW-1:0]         fcnt;
  logic [11:0]            expiry;
  logic                   out_valid;
  tetbl_pkg::result_t     out_data;

  tetbl_pkg::cell_ctrl_t  ctrl;
  tetbl_pkg::chain_t      chain [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0] wr_vec;
  logic [TABLE_ENTRIES-1:0] exp_vec;
  logic [IW-1:0]          slot_sel;
  logic [CW-1:0]          cnt [P];
  logic [CW-1:0]          exp_total;
  logic [CW-1:0]          act_new;
  logic                   accept;
  logic                   out_free;
  logic                   cfg_wr;

  assign accept   = item.valid & item.ready;
  assign out_free = ~out_valid | result.ready;
  assign item.ready   = (state == S_IDLE);
  assign result.valid = out_valid;
  assign result.data  = out_data;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[tetbl_pkg::ADDR_W-1] == tetbl_pkg::ADDR_EXPIRY[tetbl_pkg::ADDR_W-1])
                  ? {20'd0, expiry} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      expiry <= tetbl_pkg::EXPIRY_RESET;
    end else if (cfg_wr &&
                 paddr[tetbl_pkg::ADDR_W-1] == tetbl_pkg::ADDR_EXPIRY[tetbl_pkg::ADDR_W-1]) begin
      expiry <= pwdata[11:0];
    end
  end

  // Broadcast to the cells.
  assign ctrl.clear   = accept & ((item.data.opcode == tetbl_pkg::OP_INIT) ||
                                  (item.data.opcode == tetbl_pkg::OP_SHUTDOWN));
  assign ctrl.write   = (state == S_WRITE);
  assign ctrl.any_hit = chain[TABLE_ENTRIES].hit;
  assign ctrl.ident   = cur.cell_identity;
  assign ctrl.freq    = cur.carrier_freq_khz;
  assign ctrl.now     = cur.now_seconds;
  assign ctrl.record  = cur.cell_record;
  assign ctrl.expiry  = expiry;

  // The chain of cells.
  assign chain[0] = '0;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    tetbl_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1]),
      .wr        (wr_vec[g]),
      .expired   (exp_vec[g])
    );
  end

  // Index of the written cell; at most one cell writes.
  always_comb begin
    slot_sel = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (wr_vec[i]) begin
        slot_sel = slot_sel | IW'(i);
      end
    end
  end

  // Expired entries are counted by folding pairs, one tree level per cycle.
  always_ff @(posedge clk) begin
    if (state == S_WRITE) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        cnt[i] <= CW'(exp_vec[i]);
      end
      for (int i = TABLE_ENTRIES; i < P; i++) begin
        cnt[i] <= '0;
      end
    end else if (state == S_FOLD) begin
      for (int i = 0; i < P / 2; i++) begin
        cnt[i] <= cnt[2*i] + cnt[2*i+1];
      end
      for (int i = P / 2; i < P; i++) begin
        cnt[i] <= '0;
      end
    end
  end

  assign exp_total = upd ? cnt[0] : '0;
  assign act_new   = upd ? CW'(act + CW'(res_status == tetbl_pkg::STAT_INSERT) - cnt[0])
                         : act;

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      en        <= 1'b0;
      upd       <= 1'b0;
      act       <= '0;
      fcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && result.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cur      <= item.data;
            res_slot <= '0;
            upd      <= 1'b0;
            case (item.data.opcode)
              tetbl_pkg::OP_INIT, tetbl_pkg::OP_SHUTDOWN: begin
                en         <= (item.data.opcode == tetbl_pkg::OP_INIT);
                act        <= '0;
                res_status <= tetbl_pkg::STAT_CLEARED;
                state      <= S_DONE;
              end
              tetbl_pkg::OP_UPDATE: begin
                if (en) begin
                  upd   <= 1'b1;
                  state <= S_LOOK;
                end else begin
                  res_status <= tetbl_pkg::STAT_IGNORED;
                  state      <= S_DONE;
                end
              end
              default: begin
                res_status <= tetbl_pkg::STAT_IGNORED;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_LOOK: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (chain[TABLE_ENTRIES].hit) begin
            res_status <= tetbl_pkg::STAT_REFRESH;
          end else if (chain[TABLE_ENTRIES].free) begin
            res_status <= tetbl_pkg::STAT_INSERT;
          end else begin
            res_status <= tetbl_pkg::STAT_FULL;
          end
          res_slot <= slot_sel;
          fcnt     <= FCW'(LV - 1);
          state    <= S_FOLD;
        end
        S_FOLD: begin
          if (fcnt == '0) begin
            state <= S_DONE;
          end else begin
            fcnt <= fcnt - 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_data.status        <= res_status;
            out_data.slot_index    <= 6'(res_slot);
            out_data.live_count    <= 7'(act_new);
            out_data.expired_count <= 7'(exp_total);
            out_valid              <= 1'b1;
            act                    <= act_new;
            state                  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Only one cell may take the item.
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0(wr_vec))
    else $error("more than one cell written in one step");

  // A written cell never counts as expired.
  a_wr_not_expired: assert property (@(posedge clk) disable iff (rst)
    (wr_vec & exp_vec) == '0)
    else $error("written cell also expired");

  // The running count never exceeds the table size.
  a_act_bound: assert property (@(posedge clk) disable iff (rst)
    act <= CW'(TABLE_ENTRIES))
    else $error("active count above table size");

  // A clearing result reports an empty table and slot zero.
  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == tetbl_pkg::STAT_CLEARED) |->
      (out_data.live_count == '0 && out_data.slot_index == '0 &&
       out_data.expired_count == '0))
    else $error("clear result with nonzero fields");

  // Cells are written only in the write cycle of an update.
  a_wr_in_state: assert property (@(posedge clk) disable iff (rst)
    (wr_vec != '0) |-> (state == S_WRITE && en && upd))
    else $error("cell written outside an enabled update");

endmodule

FILE: hw/rtl/tetbl_cell.sv
// One table entry: key compare, age check and its link in the priority chain.
module tetbl_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  tetbl_pkg::cell_ctrl_t   ctrl,
  input  tetbl_pkg::chain_t       chain_in,
  output tetbl_pkg::chain_t       chain_out,
  output logic                    wr,
  output logic                    expired
);

  logic        valid;
  logic [8:0]  ident;
  logic [22:0] freq;
  logic [31:0] insert_time;
  logic [31:0] refresh_time;
  logic [63:0] record;
  logic        match_q;
  logic        exp_q;
  logic [31:0] age;

  // Age uses wrap-around arithmetic on 32-bit seconds.
  assign age = ctrl.now - refresh_time;

  // The first matching entry wins; otherwise the first free one does.
  assign chain_out.hit  = chain_in.hit | match_q;
  assign chain_out.free = chain_in.free | ~valid;
  assign wr = ctrl.write &
              (ctrl.any_hit ? (match_q & ~chain_in.hit) : (~valid & ~chain_in.free));

  // An entry just written has age zero and survives this step.
  assign expired = ctrl.write & valid & exp_q & ~wr;

  // Compare results are registered for the write cycle.
  always_ff @(posedge clk) begin
    match_q <= valid & (ident == ctrl.ident) & (freq == ctrl.freq);
    exp_q   <= age > {20'd0, ctrl.expiry};
  end

  // Valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.clear) begin
      valid <= 1'b0;
    end else if (wr) begin
      valid <= 1'b1;
    end else if (expired) begin
      valid <= 1'b0;
    end
  end

  // Entry contents; the key and first-seen time change only on insert.
  always_ff @(posedge clk) begin
    if (wr) begin
      refresh_time <= ctrl.now;
      record       <= ctrl.record;
      if (!ctrl.any_hit) begin
        ident       <= ctrl.ident;
        freq        <= ctrl.freq;
        insert_time <= ctrl.now;
      end
    end
  end

endmodule

FILE: tb/tb_tracked_entry_table_with_aging_core.sv
// Self-checking testbench for the tracked entry table with aging: directed and random beats.
`timescale 1ns / 100ps

module tb_tracked_entry_table_with_aging_core;

  localparam int         ENTRIES   = 64;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int         MAX_SHOWN = 10;

  // Predicts the table's response to every accepted beat and checks the results in order.
  class table_scoreboard;
    logic [11:0] expiry_s;
    bit          enabled;
    bit          live [ENTRIES];
    logic [8:0]  key_id [ENTRIES];
    logic [22:0] key_fq [ENTRIES];
    logic [31:0] insert_time [ENTRIES];
    logic [31:0] refresh_time [ENTRIES];
    logic [63:0] stored_rec [ENTRIES];
    tetbl_pkg::result_t pending_q [$];
    int          errors;

    function new();
      expiry_s = tetbl_pkg::EXPIRY_RESET;
      enabled  = 1'b0;
      errors   = 0;
      foreach (live[i]) live[i] = 1'b0;
    endfunction

    function void set_expiry(logic [11:0] v);
      expiry_s = v;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= MAX_SHOWN) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // Works out the result of one accepted beat and queues it; returns its status.
    function logic [2:0] note_item(tetbl_pkg::item_t it);
      int                 slot;
      int                 n_live;
      tetbl_pkg::result_t r;
      logic [31:0]        age;
      r    = '0;
      slot = -1;
      if (it.opcode == tetbl_pkg::OP_INIT || it.opcode == tetbl_pkg::OP_SHUTDOWN) begin
        foreach (live[i]) live[i] = 1'b0;
        enabled  = (it.opcode == tetbl_pkg::OP_INIT);
        r.status = tetbl_pkg::STAT_CLEARED;
      end else if (it.opcode != tetbl_pkg::OP_UPDATE || !enabled) begin
        r.status = tetbl_pkg::STAT_IGNORED;
      end else begin
        // Look for the same key first, then for the lowest free entry.
        for (int i = 0; i < ENTRIES; i++) begin
          if (live[i] && key_id[i] == it.cell_identity && key_fq[i] == it.carrier_freq_khz) begin
            slot = i;
            break;
          end
        end
        if (slot >= 0) begin
          r.status = tetbl_pkg::STAT_REFRESH;
        end else begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (!live[i]) begin
              slot = i;
              break;
            end
          end
          if (slot >= 0) begin
            r.status          = tetbl_pkg::STAT_INSERT;
            insert_time[slot] = it.now_seconds;
            key_id[slot]      = it.cell_identity;
            key_fq[slot]      = it.carrier_freq_khz;
          end else begin
            r.status = tetbl_pkg::STAT_FULL;
          end
        end
        if (slot >= 0) begin
          stored_rec[slot]   = it.cell_record;
          refresh_time[slot] = it.now_seconds;
          live[slot]         = 1'b1;
          r.slot_index       = slot[5:0];
        end
        // Age out with wrap-around unsigned time differences.
        for (int i = 0; i < ENTRIES; i++) begin
          age = it.now_seconds - refresh_time[i];
          if (live[i] && age > {20'b0, expiry_s}) begin
            live[i] = 1'b0;
            r.expired_count++;
          end
        end
      end
      n_live = 0;
      foreach (live[i]) if (live[i]) n_live++;
      r.live_count = n_live[6:0];
      pending_q.push_back(r);
      return r.status;
    endfunction

    // Compares one result beat with the oldest expectation.
    function void check_result(tetbl_pkg::result_t got);
      tetbl_pkg::result_t want;
      if (pending_q.size() == 0) begin
        flag($sformatf("result beat with nothing expected: status %0d slot %0d active %0d",
                       got.status, got.slot_index, got.live_count));
        return;
      end
      want = pending_q.pop_front();
      if (got.status !== want.status || got.slot_index !== want.slot_index ||
          got.live_count !== want.live_count || got.expired_count !== want.expired_count)
      begin
        flag($sformatf("expected st %0d slot %0d act %0d exp %0d, got st %0d slot %0d act %0d exp %0d",
                       want.status, want.slot_index, want.live_count, want.expired_count,
                       got.status, got.slot_index, got.live_count, got.expired_count));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [tetbl_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  bit          no_idle;
  int          stall_left;

  table_scoreboard sb;

  tetbl_item_if   item_ch ();
  tetbl_result_if result_ch ();

  tracked_entry_table_with_aging_core #(
    .TABLE_ENTRIES (ENTRIES)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Result side: ready drops in random bursts unless idling is turned off.
  initial begin
    result_ch.ready = 1'b0;
    stall_left      = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        result_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 6) - 1;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Every accepted result beat goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) sb.check_result(result_ch.data);
  end

  // Presents one beat and holds it until it is accepted.
  task automatic send_op(logic [1:0] op, logic [8:0] id, logic [22:0] fq, logic [31:0] t,
                         logic [63:0] rec, output logic [2:0] st);
    tetbl_pkg::item_t it;
    it.opcode           = op;
    it.cell_identity    = id;
    it.carrier_freq_khz = fq;
    it.now_seconds      = t;
    it.cell_record      = rec;
    @(negedge clk);
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    do @(posedge clk); while (!item_ch.ready);
    st = sb.note_item(it);
  endtask

  // Holds the item channel idle.
  task automatic pause_sender(int n);
    @(negedge clk);
    item_ch.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic drain_results();
    int waited;
    waited = 0;
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (sb.pending() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (12) @(posedge clk);
  endtask

  // Writes expiry_seconds over APB once the table is idle, then reads it back.
  task automatic write_expiry(logic [11:0] v);
    drain_results();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= tetbl_pkg::ADDR_EXPIRY;
    pwdata  <= {20'b0, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_expiry(v);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {20'b0, v}) sb.flag($sformatf("expiry read back %0h, wrote %0h", prdata, v));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // One random phase: mostly updates over a pool of keys, with clears, no-ops and time jumps.
  task automatic run_phase(int n_counted, int pool_n, int step_max, logic [31:0] start_now);
    logic [8:0]  pool_id [128];
    logic [22:0] pool_fq [128];
    logic [31:0] t;
    logic [8:0]  id;
    logic [22:0] fq;
    logic [1:0]  op;
    logic [2:0]  st;
    bit          on;
    bit          drained;
    int          counted;
    int          k;
    int          pick;

    // Keys that share an identity or a frequency with a neighbor probe each half of the match.
    for (k = 0; k < pool_n; k++) begin
      pick = $urandom_range(0, 3);
      pool_id[k] = 9'($urandom_range(0, 503));
      pool_fq[k] = 23'($urandom_range(0, 6000000));
      if (k > 0 && pick == 2) pool_id[k] = pool_id[k-1];
      if (k > 0 && pick == 3) pool_fq[k] = pool_fq[k-1];
    end

    t       = start_now;
    counted = 0;
    drained = 1'b0;
    send_op(tetbl_pkg::OP_INIT, '0, '0, t, '0, st);
    on = 1'b1;
    while (counted < n_counted) begin
      pick = $urandom_range(0, 99);
      if (!on && $urandom_range(0, 2) == 0) op = tetbl_pkg::OP_INIT;
      else if (pick < 2) op = tetbl_pkg::OP_INIT;
      else if (pick < 3) op = tetbl_pkg::OP_SHUTDOWN;
      else if (pick < 6) op = OP_UNUSED;
      else op = tetbl_pkg::OP_UPDATE;

      pick = $urandom_range(0, 99);
      if (pick < 2) t = t - $urandom_range(1, 50);
      else if (pick < 4) t = t + sb.expiry_s + $urandom_range(1, 100);
      else t = t + $urandom_range(0, step_max);

      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        k  = $urandom_range(0, pool_n - 1);
        id = pool_id[k];
        fq = pool_fq[k];
      end else if (pick < 97) begin
        id = 9'($urandom_range(0, 503));
        fq = 23'($urandom_range(0, 6000000));
      end else begin
        id = 9'($urandom);
        fq = 23'($urandom);
      end

      send_op(op, id, fq, t, {$urandom, $urandom}, st);
      if (st != tetbl_pkg::STAT_IGNORED) counted++;
      if (op == tetbl_pkg::OP_INIT) on = 1'b1;
      if (op == tetbl_pkg::OP_SHUTDOWN) on = 1'b0;

      // Halfway through, the sender waits for the table to go quiet once.
      if (!drained && counted >= n_counted / 2) begin
        drained = 1'b1;
        drain_results();
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        pause_sender($urandom_range(1, 6));
      end
    end
  endtask

  // Main sequence: reset, directed beats, random phases over several expiry settings.
  initial begin
    logic [2:0] st;
    sb             = new();
    no_idle        = 1'b0;
    rst            = 1'b1;
    item_ch.valid  = 1'b0;
    item_ch.data   = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Disabled table, unused opcode and clears before and after enabling.
    send_op(tetbl_pkg::OP_UPDATE, 9'd0, 23'd0, 32'd0, 64'd0, st);
    send_op(OP_UNUSED, 9'd5, 23'd5, 32'd1, 64'd1, st);
    send_op(tetbl_pkg::OP_SHUTDOWN, 9'd0, 23'd0, 32'd2, 64'd0, st);
    send_op(tetbl_pkg::OP_UPDATE, 9'd7, 23'd7, 32'd3, 64'd3, st);
    send_op(tetbl_pkg::OP_INIT, 9'd0, 23'd0, 32'd4, 64'd0, st);

    // Inserts at the field extremes, a refresh and keys that differ in one half only.
    send_op(tetbl_pkg::OP_UPDATE, 9'd503, 23'd6000000, 32'd100, '1, st);
    send_op(tetbl_pkg::OP_UPDATE, 9'd0, 23'd0, 32'd100, 64'd0, st);
    send_op(tetbl_pkg::OP_UPDATE, 9'd503, 23'd6000000, 32'd110, 64'h5555_5555_5555_5555, st);
    send_op(tetbl_pkg::OP_UPDATE, 9'd503, 23'd5999999, 32'd110, 64'hAAAA_AAAA_AAAA_AAAA, st);
    send_op(tetbl_pkg::OP_UPDATE, 9'd502, 23'd6000000, 32'd110, 64'h0123_4567_89AB_CDEF, st);
    send_op(OP_UNUSED, 9'd0, 23'd0, 32'd110, 64'd0, st);
    send_op(tetbl_pkg::OP_UPDATE, 9'd0, 23'd0, 32'd130, 64'd9, st);

    // Aging past the limit, then time running backwards.
    send_op(tetbl_pkg::OP_UPDATE, 9'd1, 23'd1, 32'd141, 64'd11, st);
    send_op(tetbl_pkg::OP_UPDATE, 9'd1, 23'd1, 32'd140, 64'd12, st);
    send_op(tetbl_pkg::OP_UPDATE, 9'd2, 23'd2, 32'd120, 64'd13, st);

    // Time wrapping past two to the 32, then full-width key fields.
    send_op(tetbl_pkg::OP_UPDATE, 9'd3, 23'd3, 32'hFFFF_FFF0, 64'd14, st);
    send_op(tetbl_pkg::OP_UPDATE, 9'd3, 23'd3, 32'h0000_0005, 64'd15, st);
    send_op(tetbl_pkg::OP_UPDATE, 9'h1FF, 23'h7FFFFF, 32'h0000_0010, 64'd16, st);

    // An age exactly at the limit survives; one second more expires it.
    send_op(tetbl_pkg::OP_UPDATE, 9'h1FF, 23'h7FFFFF, 32'd35, 64'd17, st);
    send_op(tetbl_pkg::OP_UPDATE, 9'h1FF, 23'h7FFFFF, 32'd36, 64'd18, st);

    // Clearing a populated table, then an update while disabled.
    send_op(tetbl_pkg::OP_SHUTDOWN, 9'd0, 23'd0, 32'd40, 64'd0, st);
    send_op(tetbl_pkg::OP_UPDATE, 9'd1, 23'd1, 32'd41, 64'd0, st);

    run_phase(250, 16, 3, 32'd1000);

    // Long expiry and a key pool larger than the table: fills it up and drops.
    write_expiry(12'd3600);
    run_phase(250, 90, 1, 32'd5000);

    write_expiry(12'd1);
    run_phase(250, 8, 2, $urandom);

    // Zero expiry keeps only entries touched in the current second.
    write_expiry(12'd0);
    run_phase(250, 8, 1, $urandom);

    write_expiry(12'd4095);
    run_phase(250, 100, 3, 32'hFFFF_FF00);

    // Last part runs without idling on either side.
    write_expiry(12'd200);
    no_idle = 1'b1;
    run_phase(250, 40, 20, $urandom);

    drain_results();
    if (sb.pending() != 0) sb.flag($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/tetbl_pkg.sv
hw/rtl/tetbl_if.sv
hw/rtl/tetbl_cell.sv
hw/rtl/tracked_entry_table_with_aging_core.sv
tb/tb_tracked_entry_table_with_aging_core.sv
